// File: src/wsts_pkg.sv
// package for the work stealing task scheduler: sizes, payload structs, codes
// no dependencies
`timescale 1ns / 1ps
package wsts_pkg;
  localparam int NumWorkers = 4;
  localparam int DequeDepth = 16;
  localparam int TaskBits   = 16;
  localparam int WidBits    = $clog2(NumWorkers);
  localparam int PtrBits    = $clog2(DequeDepth);
  localparam int CntBits    = $clog2(DequeDepth + 1);
  localparam int ActBits    = 3;
  localparam int QueueDepth = 2;

  typedef enum logic [1:0] {
    SRC_NONE   = 2'd0,
    SRC_OWN    = 2'd1,
    SRC_GLOBAL = 2'd2,
    SRC_STOLEN = 2'd3
  } src_t;

  typedef struct packed {
    logic        func;
    logic [1:0]  worker_id;
    logic        from_worker;
    logic [15:0] task_id;
  } in_item_t;

  typedef struct packed {
    logic [15:0] task_id_out;
    logic [1:0]  source;
    logic [1:0]  victim;
    logic        dropped;
  } out_item_t;

  // classified command handed from front to back
  typedef struct packed {
    logic                push;
    logic                to_global;
    logic                nop;
    logic [WidBits-1:0]  wid;
    logic [TaskBits-1:0] task_id;
  } cmd_t;
endpackage

// File: src/wsts_ram.sv
// generic single write, single registered read ram
// no dependencies
`timescale 1ns / 1ps
module wsts_ram #(
  parameter int Width = 16,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: src/wsts_front.sv
// front end: takes input beats, checks the worker against the active count, queues commands
// depends on wsts_pkg
`timescale 1ns / 1ps
module wsts_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  wsts_pkg::in_item_t          in_data,
  input  logic [wsts_pkg::WidBits:0]  act,
  output logic                        cmd_valid,
  input  logic                        cmd_ready,
  output wsts_pkg::cmd_t              cmd
);
  import wsts_pkg::*;

  localparam int QPtr = $clog2(QueueDepth);

  cmd_t              q_r [QueueDepth];
  logic [QPtr-1:0]   wp_r, rp_r;
  logic [QPtr:0]     cnt_r;
  cmd_t              c_nxt;
  logic              push_in, pop_out;

  // classify the incoming beat
  always_comb begin
    c_nxt.push      = ~in_data.func;
    c_nxt.to_global = ~in_data.func & ~in_data.from_worker;
    c_nxt.wid       = in_data.worker_id[WidBits-1:0];
    c_nxt.task_id   = in_data.task_id[TaskBits-1:0];
    c_nxt.nop       = ~c_nxt.to_global &
                      ({1'b0, in_data.worker_id[WidBits-1:0]} >= act);
  end

  assign in_ready  = (cnt_r != QueueDepth[QPtr:0]);
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rp_r];
  assign push_in   = in_valid & in_ready;
  assign pop_out   = cmd_valid & cmd_ready;

  // command queue between front and back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push_in) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop_out) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + {{QPtr{1'b0}}, push_in} - {{QPtr{1'b0}}, pop_out};
    end
    if (push_in) begin
      q_r[wp_r] <= c_nxt;
    end
  end
endmodule

// File: src/wsts_back.sv
// back end: deque bookkeeping, steal scan and the task memory access
// depends on wsts_pkg, wsts_ram
`timescale 1ns / 1ps
module wsts_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cmd_valid,
  output logic                       cmd_ready,
  input  wsts_pkg::cmd_t             cmd,
  input  logic [wsts_pkg::WidBits:0] act,
  output logic                       out_valid,
  input  logic                       out_ready,
  output wsts_pkg::out_item_t        out_data
);
  import wsts_pkg::*;

  localparam int QN      = NumWorkers + 1;   // global deque is the last
  localparam int QBits   = $clog2(QN);
  localparam int AddrBits = QBits + PtrBits;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_ADDR, S_READ, S_OUT} state_t;

  state_t              state_r;
  logic [PtrBits-1:0]  head_r [QN];
  logic [CntBits-1:0]  cnt_r  [QN];
  cmd_t                cmd_r;
  logic [WidBits:0]    scan_r;      // offset of victim after requester
  logic [QBits-1:0]    tgt_r;
  logic [PtrBits-1:0]  slot_r;
  src_t                src_r;
  logic                hit_r;
  out_item_t           out_r;

  logic                we;
  logic [AddrBits-1:0] waddr, raddr;
  logic [TaskBits-1:0] rdata;
  logic [QBits-1:0]    gq, own_q, vic_q;
  logic [WidBits:0]    vic_sum;

  assign gq    = QBits'(NumWorkers);
  assign own_q = QBits'(cmd_r.wid);
  // victim index: (wid + scan) mod act, sum stays below twice act
  assign vic_sum = {1'b0, cmd_r.wid} + scan_r;
  assign vic_q   = (vic_sum >= act) ? QBits'(vic_sum - act) : QBits'(vic_sum);

  assign we    = (state_r == S_IDLE) && cmd_valid && cmd.push && !cmd.nop &&
                 (cnt_r[cmd.to_global ? gq : QBits'(cmd.wid)] != CntBits'(DequeDepth));
  assign waddr = {cmd.to_global ? gq : QBits'(cmd.wid),
                  head_r[cmd.to_global ? gq : QBits'(cmd.wid)] - 1'b1};
  assign raddr = {tgt_r, slot_r};

  wsts_ram #(.Width(TaskBits), .Depth(1 << AddrBits)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (cmd.task_id),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign cmd_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = out_r;

  // sequencer: a push goes straight to output, a request scans and then reads
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < QN; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r  <= cmd;
            // a push that finds its deque full reports a drop
            out_r  <= '{task_id_out: '0, source: '0, victim: '0,
                        dropped: cmd.push && !cmd.nop && !we};
            scan_r <= '0;
            hit_r  <= 1'b0;
            if (cmd.nop) begin
              state_r <= S_OUT;
            end else if (cmd.push) begin
              if (we) begin
                head_r[waddr[AddrBits-1:PtrBits]] <= waddr[PtrBits-1:0];
                cnt_r[waddr[AddrBits-1:PtrBits]]  <=
                  cnt_r[waddr[AddrBits-1:PtrBits]] + 1'b1;
              end
              state_r <= S_OUT;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // own deque, then global, then one victim per cycle
          if (cnt_r[own_q] != '0 && scan_r == '0 && !hit_r) begin
            tgt_r  <= own_q;
            slot_r <= head_r[own_q];
            head_r[own_q] <= head_r[own_q] + 1'b1;
            cnt_r[own_q]  <= cnt_r[own_q] - 1'b1;
            src_r  <= SRC_OWN;
            state_r <= S_ADDR;
          end else if (!hit_r && cnt_r[gq] != '0) begin
            tgt_r  <= gq;
            slot_r <= head_r[gq] + PtrBits'(cnt_r[gq] - 1'b1);
            cnt_r[gq] <= cnt_r[gq] - 1'b1;
            src_r  <= SRC_GLOBAL;
            state_r <= S_ADDR;
          end else if (!hit_r) begin
            hit_r  <= 1'b1;       // marks own and global checked
            scan_r <= (WidBits+1)'(1);
          end else if (scan_r >= act) begin
            state_r <= S_OUT;
          end else if (cnt_r[vic_q] != '0) begin
            tgt_r  <= vic_q;
            slot_r <= head_r[vic_q] + PtrBits'(cnt_r[vic_q] - 1'b1);
            cnt_r[vic_q] <= cnt_r[vic_q] - 1'b1;
            src_r  <= SRC_STOLEN;
            state_r <= S_ADDR;
          end else begin
            scan_r <= scan_r + 1'b1;
          end
        end
        S_ADDR: begin
          // read address is stable, ram data registers at this edge
          state_r <= S_READ;
        end
        S_READ: begin
          out_r <= '{task_id_out: rdata, source: src_r,
                     victim: (src_r == SRC_STOLEN) ? 2'(tgt_r) : 2'd0,
                     dropped: 1'b0};
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// File: src/work_stealing_task_scheduler_core.sv
// top level of the work stealing task scheduler
// depends on wsts_pkg, wsts_front, wsts_back, wsts_ram
`timescale 1ns / 1ps
// usage:
// input channel in_valid/in_ready/in_data carries push and request beats;
// result channel out_valid/out_ready/out_data returns exactly one beat per
// input beat, in order. cfg_we/cfg_wdata writes active_workers (0 acts as 1,
// above four acts as four); write it only while idle.
// a push goes from back end idle straight to its result; a request passes
// through the back end checking own and global deque, then one victim deque
// per cycle, followed by one registered read of the task memory.
// the front end queues two beats, so input keeps flowing while the back end
// works or the receiver stalls; a stalled result holds in its register.
// reset (rst_n low, synchronous) empties all deques and sets four workers;
// no clearing pass is needed, task memory is only read where written.
module work_stealing_task_scheduler_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  wsts_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output wsts_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_wdata
);
  import wsts_pkg::*;

  logic [ActBits-1:0] act_r;
  logic [WidBits:0]   act;
  logic               cmd_valid, cmd_ready;
  cmd_t               cmd;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= ActBits'(NumWorkers);
    end else if (cfg_we) begin
      act_r <= cfg_wdata;
    end
  end

  // clamp active count into one through NumWorkers
  always_comb begin
    if (act_r == '0) begin
      act = (WidBits+1)'(1);
    end else if (act_r > ActBits'(NumWorkers)) begin
      act = (WidBits+1)'(NumWorkers);
    end else begin
      act = (WidBits+1)'(act_r);
    end
  end

  wsts_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .act       (act),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  wsts_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .act       (act),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );
endmodule

// File: dv/work_stealing_task_scheduler_core_test.sv
// testbench for the work stealing task scheduler core: directed table, then random beats
// checked against a behavioral deque scheduler; depends on wsts_pkg and the core rtl
`timescale 1ns / 1ps
module work_stealing_task_scheduler_core_test;
  import wsts_pkg::*;

  localparam int IdleTimeout = 20000;
  localparam int SettleCycles = 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_wdata = '0;

  always #5 clk = ~clk;

  work_stealing_task_scheduler_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // scheduler state mirror
  logic [15:0] wk_slot [NumWorkers][DequeDepth];
  int wk_head [NumWorkers];
  int wk_cnt [NumWorkers];
  logic [15:0] gl_slot [DequeDepth];
  int gl_head, gl_cnt;
  logic [2:0] act_reg;

  out_item_t pending_results[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit drain_hold = 1'b0;   // long receiver hold-off
  bit stalls_on = 1'b1;

  function automatic out_item_t schedule(in_item_t it);
    out_item_t r;
    int act, w, o;
    bit hit;
    r = '0;
    act = (act_reg == 0) ? 1 : (act_reg > NumWorkers ? NumWorkers : act_reg);
    w = it.worker_id;
    hit = 1'b0;
    if (!it.func) begin
      if (!it.from_worker) begin
        if (gl_cnt >= DequeDepth) r.dropped = 1'b1;
        else begin
          gl_head = (gl_head + DequeDepth - 1) % DequeDepth;
          gl_slot[gl_head] = it.task_id;
          gl_cnt++;
        end
      end else if (w < act) begin
        if (wk_cnt[w] >= DequeDepth) r.dropped = 1'b1;
        else begin
          wk_head[w] = (wk_head[w] + DequeDepth - 1) % DequeDepth;
          wk_slot[w][wk_head[w]] = it.task_id;
          wk_cnt[w]++;
        end
      end
    end else if (w < act) begin
      if (wk_cnt[w] > 0) begin
        r.task_id_out = wk_slot[w][wk_head[w]];
        wk_head[w] = (wk_head[w] + 1) % DequeDepth;
        wk_cnt[w]--;
        r.source = SRC_OWN;
      end else if (gl_cnt > 0) begin
        r.task_id_out = gl_slot[(gl_head + gl_cnt - 1) % DequeDepth];
        gl_cnt--;
        r.source = SRC_GLOBAL;
      end else begin
        // one steal, scanning after the requester
        for (int i = 0; i + 1 < act; i++) begin
          o = (w + 1 + i) % act;
          if (!hit && wk_cnt[o] > 0) begin
            r.task_id_out = wk_slot[o][(wk_head[o] + wk_cnt[o] - 1) % DequeDepth];
            wk_cnt[o]--;
            r.source = SRC_STOLEN;
            r.victim = o[1:0];
            hit = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

  // directed table: expected typed only where obvious, else predicted
  typedef struct {
    in_item_t beat;
    bit has_fixed;
    out_item_t fixed;
  } row_t;
  row_t dir_rows[$];

  function automatic in_item_t mk(bit f, int w, bit fw, int t);
    in_item_t b;
    b.func = f; b.worker_id = w[1:0]; b.from_worker = fw; b.task_id = t[15:0];
    return b;
  endfunction

  function automatic out_item_t ex(int t, src_t s, int v, bit d);
    out_item_t o;
    o.task_id_out = t[15:0]; o.source = s; o.victim = v[1:0]; o.dropped = d;
    return o;
  endfunction

  // send one beat and log its prediction; valid stays up until the next
  // idle cycle or the next beat
  task automatic send_beat(in_item_t b, bit has_fixed, out_item_t fixed, bit gaps);
    out_item_t p;
    while (gaps && stalls_on && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p = schedule(b);
    if (has_fixed && p !== fixed)
      $display("table row disagrees with predictor: %h vs %h", fixed, p);
    pending_results.push_back(has_fixed ? fixed : p);
  endtask

  task automatic wait_empty();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_active(int v);
    cfg_we <= 1'b1;
    cfg_wdata <= v[2:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    act_reg = v[2:0];
  endtask

  function automatic in_item_t rand_beat();
    in_item_t b;
    b.func = ($urandom_range(99) < 50);
    b.worker_id = 2'($urandom_range(3));
    b.from_worker = ($urandom_range(99) < 60);
    b.task_id = 16'($urandom);
    return b;
  endfunction

  // receiver
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= !drain_hold && !(stalls_on && $urandom_range(99) < 26);
  end

  // result check
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", out_data);
      end else begin
        out_item_t e;
        e = pending_results[0];
        pending_results.delete(0);
        if (out_data.task_id_out !== e.task_id_out || out_data.source !== e.source ||
            out_data.victim !== e.victim || out_data.dropped !== e.dropped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected task %h src %0d vic %0d drop %0d, got %h %0d %0d %0d",
                     e.task_id_out, e.source, e.victim, e.dropped, out_data.task_id_out,
                     out_data.source, out_data.victim, out_data.dropped);
        end
      end
    end
  end

  // watchdog on accepted beats
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleTimeout) begin
      $display("simulation failed");
      $finish;
    end
  end

  // long receiver hold-off so the input stalls
  task automatic hold_receiver(int cycles);
    drain_hold = 1'b1;
    repeat (cycles) @(posedge clk);
    drain_hold = 1'b0;
  endtask

  initial begin
    in_item_t b;
    int n;
    for (int w = 0; w < NumWorkers; w++) begin
      wk_head[w] = 0; wk_cnt[w] = 0;
    end
    gl_head = 0; gl_cnt = 0; act_reg = 3'd4;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows: empty request, extremes, own/global/steal
    dir_rows.push_back('{mk(1, 0, 0, 16'h1234), 1'b1, ex(0, SRC_NONE, 0, 0)});
    dir_rows.push_back('{mk(0, 1, 1, 16'hffff), 1'b1, ex(0, SRC_NONE, 0, 0)});
    dir_rows.push_back('{mk(1, 1, 0, 0), 1'b1, ex(16'hffff, SRC_OWN, 0, 0)});
    dir_rows.push_back('{mk(0, 3, 0, 16'h0000), 1'b1, ex(0, SRC_NONE, 0, 0)});
    dir_rows.push_back('{mk(0, 2, 0, 16'ha5a5), 1'b1, ex(0, SRC_NONE, 0, 0)});
    dir_rows.push_back('{mk(1, 3, 1, 0), 1'b1, ex(16'h0000, SRC_GLOBAL, 0, 0)});
    dir_rows.push_back('{mk(1, 3, 1, 0), 1'b1, ex(16'ha5a5, SRC_GLOBAL, 0, 0)});
    dir_rows.push_back('{mk(0, 1, 1, 16'h0001), 1'b0, '0});
    dir_rows.push_back('{mk(0, 2, 1, 16'h8000), 1'b0, '0});
    dir_rows.push_back('{mk(1, 3, 0, 0), 1'b1, ex(16'h0001, SRC_STOLEN, 1, 0)});
    dir_rows.push_back('{mk(1, 0, 0, 0), 1'b1, ex(16'h8000, SRC_STOLEN, 2, 0)});
    foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].has_fixed,
                                    dir_rows[i].fixed, 1'b0);
    wait_empty();

    // fill worker 0 and global past full to hit the dropped flag
    for (int i = 0; i < DequeDepth + 1; i++) send_beat(mk(0, 0, 1, i), 1'b0, '0, 1'b1);
    for (int i = 0; i < DequeDepth + 1; i++) send_beat(mk(0, 0, 0, 100 + i), 1'b0, '0, 1'b1);
    wait_empty();

    // inactive worker and out-of-range register values
    write_active(1);
    send_beat(mk(0, 2, 1, 16'h5555), 1'b1, ex(0, SRC_NONE, 0, 0), 1'b0);
    send_beat(mk(1, 3, 0, 0), 1'b1, ex(0, SRC_NONE, 0, 0), 1'b0);
    wait_empty();
    write_active(0);
    send_beat(mk(1, 1, 0, 0), 1'b1, ex(0, SRC_NONE, 0, 0), 1'b0);
    wait_empty();
    write_active(7);

    // receiver holds off while the sender keeps offering
    fork
      hold_receiver(60);
      for (int i = 0; i < 12; i++) send_beat(rand_beat(), 1'b0, '0, 1'b0);
    join
    wait_empty();

    // random phases across register settings
    for (int ph = 0; ph < 6; ph++) begin
      write_active(ph == 5 ? 4 : $urandom_range(7));
      stalls_on = (ph != 2);
      n = 65;
      for (int i = 0; i < n; i++) begin
        b = rand_beat();
        // mostly keep the worker active so requests and pushes do real work
        if ($urandom_range(99) < 85) b.worker_id = 2'($urandom_range(
            ((act_reg == 0) ? 1 : (act_reg > 4 ? 4 : act_reg)) - 1));
        send_beat(b, 1'b0, '0, 1'b1);
      end
      wait_empty();
    end
    stalls_on = 1'b1;

    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
